FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while reset is high.
`define JDHT_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Implication checked in the next cycle, masked while reset is high.
`define JDHT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// Implication checked in the next cycle, active during reset too.
`define JDHT_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

FILE: hdl/jdht_pkg.sv
// Package: sizes, codes, types and helpers of the DHT table builder.
`default_nettype none
package jdht_pkg;

   localparam int FAST_BITS        = 9;
   localparam int TABLES_PER_CLASS = 4;
   localparam int OVERFLOW_PAIRS   = 127;

   localparam int TAB_W      = 3;
   localparam int NLISTS     = 16 - FAST_BITS;
   localparam int LIST_W     = $clog2(NLISTS);
   localparam int SLOT_W     = $clog2(OVERFLOW_PAIRS);
   localparam int CNT_W      = $clog2(OVERFLOW_PAIRS + 1);
   localparam int FAST_AW    = TAB_W + FAST_BITS;
   localparam int FAST_DEPTH = 1 << FAST_AW;
   localparam int SL_AW      = TAB_W + 8;
   localparam int SL_DEPTH   = 1 << SL_AW;
   localparam int OC_AW      = TAB_W + LIST_W;
   localparam int OC_DEPTH   = 1 << OC_AW;
   localparam int OE_AW      = TAB_W + LIST_W + SLOT_W;
   localparam int OE_DEPTH   = 1 << OE_AW;
   localparam int SWEEP_W    = (FAST_AW > SL_AW) ? FAST_AW : SL_AW;

   localparam logic [1:0] FUNC_DHT  = 2'd0;
   localparam logic [1:0] FUNC_FAST = 2'd1;
   localparam logic [1:0] FUNC_OVF  = 2'd2;

   localparam logic [1:0] KIND_DHT  = 2'd0;
   localparam logic [1:0] KIND_FAST = 2'd1;
   localparam logic [1:0] KIND_OVF  = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_ID    = 3'd1;
   localparam logic [2:0] ERR_TOO_MANY  = 3'd2;
   localparam logic [2:0] ERR_CODE_OVF  = 3'd3;
   localparam logic [2:0] ERR_LIST_FULL = 3'd4;

   localparam logic [8:0] SYM_EMPTY = 9'h1ff;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic       sel_class;
      logic [1:0] sel_table;
      logic [8:0] sel_index;
      logic [2:0] sel_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  symbol;
      logic [15:0] code;
      logic [4:0]  code_length;
      logic        entry_valid;
      logic        segment_done;
      logic [2:0]  error_code;
   } res_type;

   function automatic logic [TAB_W-1:0] tab_index(input logic cls, input logic [3:0] id);
      tab_index = TAB_W'(32'(cls) * TABLES_PER_CLASS + 32'(id));
   endfunction

   function automatic logic [16:0] sat_code(input logic [17:0] x);
      sat_code = (x > 18'h10000) ? 17'h10000 : x[16:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/jdht_ram.sv
// Generic RAM: one write port, one registered read port.
`default_nettype none
module jdht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: hdl/jdht_ctrl.sv
// Parser and table sequencer with the table memories.
`default_nettype none
module jdht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire jdht_pkg::req_type req,
   output logic                   req_ready,
   output logic                   res_valid,
   output jdht_pkg::res_type      res,
   input  wire logic              res_ready
);
   localparam int FB      = jdht_pkg::FAST_BITS;
   localparam int TAB_W   = jdht_pkg::TAB_W;
   localparam int LIST_W  = jdht_pkg::LIST_W;
   localparam int SLOT_W  = jdht_pkg::SLOT_W;
   localparam int CNT_W   = jdht_pkg::CNT_W;
   localparam int SWEEP_W = jdht_pkg::SWEEP_W;
   localparam int FAST_AW = jdht_pkg::FAST_AW;
   localparam int SL_AW   = jdht_pkg::SL_AW;
   localparam int OC_AW   = jdht_pkg::OC_AW;
   localparam int OE_AW   = jdht_pkg::OE_AW;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DHT  = 4'd2;
   localparam logic [3:0] S_CLR  = 4'd3;
   localparam logic [3:0] S_SRCH = 4'd4;
   localparam logic [3:0] S_ASG  = 4'd5;
   localparam logic [3:0] S_FILL = 4'd6;
   localparam logic [3:0] S_OC   = 4'd7;
   localparam logic [3:0] S_FR1  = 4'd8;
   localparam logic [3:0] S_FR2  = 4'd9;
   localparam logic [3:0] S_OR1  = 4'd10;
   localparam logic [3:0] S_OR2  = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   localparam logic [2:0] PH_LEN_HI = 3'd0;
   localparam logic [2:0] PH_LEN_LO = 3'd1;
   localparam logic [2:0] PH_CLASS  = 3'd2;
   localparam logic [2:0] PH_COUNTS = 3'd3;
   localparam logic [2:0] PH_SYMS   = 3'd4;

   logic [3:0]         state_ff, state_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   jdht_pkg::req_type  in_ff, in_in;
   logic [2:0]         phase_ff, phase_in;
   logic [15:0]        seg_rem_ff, seg_rem_in;
   logic [16:0]        nc_ff, nc_in;
   logic [4:0]         cur_len_ff, cur_len_in;
   logic [7:0]         left_ff, left_in;
   logic [11:0]        sym_left_ff, sym_left_in;
   logic [TAB_W-1:0]   act_ff, act_in;
   logic [2:0]         sticky_ff, sticky_in;
   logic               drop_ff, drop_in;
   logic [7:0]         lc_ff [16];
   logic [7:0]         lc_in [16];
   logic [2:0]         err_ff, err_in;
   logic               emit_ff, emit_in;
   logic [15:0]        code_ff, code_in;
   logic [4:0]         len_ff, len_in;
   logic               valid_ff, valid_in;
   logic [8:0]         sym_ff, sym_in;
   logic [FB-1:0]      fill_ff, fill_in;
   logic [FB-1:0]      fill_cnt_ff, fill_cnt_in;
   logic [FB-1:0]      fill_last_ff, fill_last_in;
   jdht_pkg::res_type  res_ff, res_in;

   logic               fast_we;
   logic [FAST_AW-1:0] fast_wa, fast_ra;
   logic [8:0]         fast_wd, fast_rd;
   logic               sl_we;
   logic [SL_AW-1:0]   sl_wa, sl_ra;
   logic [4:0]         sl_wd, sl_rd;
   logic               oc_we;
   logic [OC_AW-1:0]   oc_wa, oc_ra;
   logic [CNT_W-1:0]   oc_wd, oc_rd;
   logic               oe_we;
   logic [OE_AW-1:0]   oe_wa, oe_ra;
   logic [23:0]        oe_wd, oe_rd;

   logic [TAB_W-1:0]   req_tab, rd_tab, hdr_tab;
   logic [15:0]        total;
   logic [11:0]        sum;
   logic [11:0]        nleft;
   logic [LIST_W-1:0]  lst;
   logic [4:0]         sh;
   logic [2:0]         sticky_new;
   logic               done;
   logic               rd_bad;

   jdht_ram #(.WIDTH(9), .DEPTH(jdht_pkg::FAST_DEPTH)) u_fast (
      .clock(clock), .wr_en(fast_we), .wr_addr(fast_wa), .wr_data(fast_wd),
      .rd_addr(fast_ra), .rd_data(fast_rd));
   jdht_ram #(.WIDTH(5), .DEPTH(jdht_pkg::SL_DEPTH)) u_symlen (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_wa), .wr_data(sl_wd),
      .rd_addr(sl_ra), .rd_data(sl_rd));
   jdht_ram #(.WIDTH(CNT_W), .DEPTH(jdht_pkg::OC_DEPTH)) u_ocnt (
      .clock(clock), .wr_en(oc_we), .wr_addr(oc_wa), .wr_data(oc_wd),
      .rd_addr(oc_ra), .rd_data(oc_rd));
   jdht_ram #(.WIDTH(24), .DEPTH(jdht_pkg::OE_DEPTH)) u_oentry (
      .clock(clock), .wr_en(oe_we), .wr_addr(oe_wa), .wr_data(oe_wd),
      .rd_addr(oe_ra), .rd_data(oe_rd));

   assign req_tab = jdht_pkg::tab_index(req.sel_class, {2'b00, req.sel_table});
   assign rd_tab  = jdht_pkg::tab_index(in_ff.sel_class, {2'b00, in_ff.sel_table});
   assign hdr_tab = jdht_pkg::tab_index(in_ff.data_byte[7:4] != 4'h0, in_ff.data_byte[3:0]);
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res       = res_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      in_in        = in_ff;
      phase_in     = phase_ff;
      seg_rem_in   = seg_rem_ff;
      nc_in        = nc_ff;
      cur_len_in   = cur_len_ff;
      left_in      = left_ff;
      sym_left_in  = sym_left_ff;
      act_in       = act_ff;
      sticky_in    = sticky_ff;
      drop_in      = drop_ff;
      lc_in        = lc_ff;
      err_in       = err_ff;
      emit_in      = emit_ff;
      code_in      = code_ff;
      len_in       = len_ff;
      valid_in     = valid_ff;
      sym_in       = sym_ff;
      fill_in      = fill_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_last_in = fill_last_ff;
      res_in       = res_ff;
      fast_we = 1'b0; fast_wa = '0; fast_wd = '0; fast_ra = '0;
      sl_we   = 1'b0; sl_wa   = '0; sl_wd   = '0; sl_ra   = '0;
      oc_we   = 1'b0; oc_wa   = '0; oc_wd   = '0; oc_ra   = '0;
      oe_we   = 1'b0; oe_wa   = '0; oe_wd   = '0; oe_ra   = '0;
      total      = {seg_rem_ff[15:8], in_ff.data_byte};
      sum        = sym_left_ff + 12'(in_ff.data_byte);
      nleft      = (sym_left_ff != 12'd0) ? sym_left_ff - 12'd1 : 12'd0;
      lst        = LIST_W'(32'(len_ff) - FB - 1);
      sh         = 5'(FB - 32'(cur_len_ff));
      done       = (seg_rem_ff == 16'd0);
      sticky_new = (err_ff != jdht_pkg::ERR_NONE && sticky_ff == jdht_pkg::ERR_NONE) ?
                   err_ff : sticky_ff;
      rd_bad     = 1'b0;

      case (state_ff)
         S_INIT: begin
            // Power-up sweep: empty every fast entry, zero lengths and counts.
            if (32'(sweep_ff) < jdht_pkg::FAST_DEPTH) begin
               fast_we = 1'b1;
               fast_wa = FAST_AW'(sweep_ff);
               fast_wd = jdht_pkg::SYM_EMPTY;
            end
            if (32'(sweep_ff) < jdht_pkg::SL_DEPTH) begin
               sl_we = 1'b1;
               sl_wa = SL_AW'(sweep_ff);
            end
            if (32'(sweep_ff) < jdht_pkg::OC_DEPTH) begin
               oc_we = 1'b1;
               oc_wa = OC_AW'(sweep_ff);
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               in_in    = req;
               err_in   = jdht_pkg::ERR_NONE;
               emit_in  = 1'b0;
               code_in  = '0;
               len_in   = '0;
               valid_in = 1'b0;
               sym_in   = '0;
               fast_ra  = {req_tab, FB'(req.sel_index)};
               oc_ra    = {req_tab, LIST_W'(req.sel_length)};
               case (req.func)
                  jdht_pkg::FUNC_DHT:  state_in = S_DHT;
                  jdht_pkg::FUNC_FAST: state_in = S_FR1;
                  jdht_pkg::FUNC_OVF:  state_in = S_OR1;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_DHT: begin
            case (phase_ff)
               PH_LEN_HI: begin
                  seg_rem_in = {in_ff.data_byte, 8'h00};
                  sticky_in  = jdht_pkg::ERR_NONE;
                  phase_in   = PH_LEN_LO;
                  state_in   = S_IDLE;
               end
               PH_LEN_LO: begin
                  seg_rem_in = (total > 16'd2) ? total - 16'd2 : 16'd0;
                  phase_in   = PH_CLASS;
                  state_in   = S_FIN;
               end
               default: begin
                  seg_rem_in = (seg_rem_ff != 16'd0) ? seg_rem_ff - 16'd1 : seg_rem_ff;
                  case (phase_ff)
                     PH_CLASS: begin
                        for (int i = 0; i < 16; i++) begin
                           lc_in[i] = 8'h00;
                        end
                        cur_len_in  = '0;
                        sym_left_in = '0;
                        phase_in    = PH_COUNTS;
                        if (32'(in_ff.data_byte[3:0]) >= jdht_pkg::TABLES_PER_CLASS) begin
                           drop_in  = 1'b1;
                           err_in   = jdht_pkg::ERR_BAD_ID;
                           state_in = S_FIN;
                        end else begin
                           act_in   = hdr_tab;
                           drop_in  = 1'b0;
                           sweep_in = '0;
                           state_in = S_CLR;
                        end
                     end
                     PH_COUNTS: begin
                        lc_in[cur_len_ff[3:0]] = in_ff.data_byte;
                        sym_left_in = sum;
                        state_in    = S_FIN;
                        if (cur_len_ff == 5'd15) begin
                           if (sum > 12'd256 && !drop_ff) begin
                              drop_in = 1'b1;
                              err_in  = jdht_pkg::ERR_TOO_MANY;
                           end
                           nc_in      = '0;
                           cur_len_in = '0;
                           left_in    = '0;
                           phase_in   = (sum != 12'd0) ? PH_SYMS : PH_CLASS;
                        end else begin
                           cur_len_in = cur_len_ff + 5'd1;
                        end
                     end
                     default: begin
                        emit_in     = 1'b1;
                        sym_in      = {1'b0, in_ff.data_byte};
                        sym_left_in = nleft;
                        if (nleft == 12'd0) begin
                           phase_in = PH_CLASS;
                        end
                        state_in = drop_ff ? S_FIN : S_SRCH;
                     end
                  endcase
               end
            endcase
         end
         S_CLR: begin
            // Table start: empty the fast table, zero its overflow counts.
            fast_we = 1'b1;
            fast_wa = {act_ff, sweep_ff[FB-1:0]};
            fast_wd = jdht_pkg::SYM_EMPTY;
            if (32'(sweep_ff) < (1 << LIST_W)) begin
               oc_we = 1'b1;
               oc_wa = {act_ff, sweep_ff[LIST_W-1:0]};
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[FB-1:0] == '1) begin
               state_in = S_FIN;
            end
         end
         S_SRCH: begin
            // Step one code length per cycle until a nonzero count.
            if (left_ff != 8'd0) begin
               state_in = S_ASG;
            end else if (cur_len_ff < 5'd16) begin
               nc_in      = jdht_pkg::sat_code({nc_ff, 1'b0});
               cur_len_in = cur_len_ff + 5'd1;
               if (lc_ff[cur_len_ff[3:0]] != 8'd0) begin
                  left_in = lc_ff[cur_len_ff[3:0]];
               end
            end else begin
               err_in   = jdht_pkg::ERR_CODE_OVF;
               state_in = S_FIN;
            end
         end
         S_ASG: begin
            left_in = left_ff - 8'd1;
            nc_in   = jdht_pkg::sat_code({1'b0, nc_ff} + 18'd1);
            if ((nc_ff >> cur_len_ff) != 17'd0) begin
               err_in   = jdht_pkg::ERR_CODE_OVF;
               state_in = S_FIN;
            end else begin
               code_in = nc_ff[15:0];
               len_in  = cur_len_ff;
               if (32'(cur_len_ff) <= FB) begin
                  fill_in      = FB'(32'(nc_ff) << sh);
                  fill_cnt_in  = '0;
                  fill_last_in = FB'((32'd1 << sh) - 32'd1);
                  state_in     = S_FILL;
               end else begin
                  oc_ra    = {act_ff, LIST_W'(32'(cur_len_ff) - FB - 1)};
                  state_in = S_OC;
               end
            end
         end
         S_FILL: begin
            fast_we     = 1'b1;
            fast_wa     = {act_ff, fill_ff};
            fast_wd     = sym_ff;
            fill_in     = fill_ff + 1'b1;
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == fill_last_ff) begin
               sl_we    = 1'b1;
               sl_wa    = {act_ff, sym_ff[7:0]};
               sl_wd    = len_ff;
               valid_in = 1'b1;
               state_in = S_FIN;
            end
         end
         S_OC: begin
            if (32'(oc_rd) >= jdht_pkg::OVERFLOW_PAIRS) begin
               err_in = jdht_pkg::ERR_LIST_FULL;
            end else begin
               oe_we    = 1'b1;
               oe_wa    = {act_ff, lst, oc_rd[SLOT_W-1:0]};
               oe_wd    = {code_ff, sym_ff[7:0]};
               oc_we    = 1'b1;
               oc_wa    = {act_ff, lst};
               oc_wd    = oc_rd + 1'b1;
               sl_we    = 1'b1;
               sl_wa    = {act_ff, sym_ff[7:0]};
               sl_wd    = len_ff;
               valid_in = 1'b1;
            end
            state_in = S_FIN;
         end
         S_FR1: begin
            res_in = '{kind: jdht_pkg::KIND_FAST, symbol: jdht_pkg::SYM_EMPTY, code: '0,
                       code_length: '0, entry_valid: 1'b0, segment_done: 1'b0,
                       error_code: jdht_pkg::ERR_NONE};
            if (32'(in_ff.sel_table) >= jdht_pkg::TABLES_PER_CLASS || fast_rd[8]) begin
               state_in = S_OUT;
            end else begin
               sym_in   = fast_rd;
               sl_ra    = {rd_tab, fast_rd[7:0]};
               state_in = S_FR2;
            end
         end
         S_FR2: begin
            res_in = '{kind: jdht_pkg::KIND_FAST, symbol: sym_ff, code: '0,
                       code_length: sl_rd, entry_valid: 1'b1, segment_done: 1'b0,
                       error_code: jdht_pkg::ERR_NONE};
            state_in = S_OUT;
         end
         S_OR1: begin
            rd_bad = 32'(in_ff.sel_table) >= jdht_pkg::TABLES_PER_CLASS ||
                     32'(in_ff.sel_length) >= jdht_pkg::NLISTS ||
                     32'(in_ff.sel_index) >= jdht_pkg::OVERFLOW_PAIRS ||
                     32'(in_ff.sel_index) >= 32'(oc_rd);
            res_in = '{kind: jdht_pkg::KIND_OVF, symbol: '0, code: '0, code_length: '0,
                       entry_valid: 1'b0, segment_done: 1'b0,
                       error_code: jdht_pkg::ERR_NONE};
            if (rd_bad) begin
               state_in = S_OUT;
            end else begin
               oe_ra    = {rd_tab, LIST_W'(in_ff.sel_length), SLOT_W'(in_ff.sel_index)};
               state_in = S_OR2;
            end
         end
         S_OR2: begin
            res_in = '{kind: jdht_pkg::KIND_OVF, symbol: {1'b0, oe_rd[7:0]},
                       code: oe_rd[23:8],
                       code_length: 5'(32'(in_ff.sel_length) + FB + 1),
                       entry_valid: 1'b1, segment_done: 1'b0,
                       error_code: jdht_pkg::ERR_NONE};
            state_in = S_OUT;
         end
         S_FIN: begin
            sticky_in = sticky_new;
            if (done) begin
               phase_in = PH_LEN_HI;
            end
            res_in = '{kind: jdht_pkg::KIND_DHT, symbol: sym_ff, code: code_ff,
                       code_length: len_ff, entry_valid: valid_ff, segment_done: done,
                       error_code: (err_ff != jdht_pkg::ERR_NONE) ? err_ff :
                                   (done ? sticky_new : jdht_pkg::ERR_NONE)};
            if (emit_ff || err_ff != jdht_pkg::ERR_NONE || done) begin
               state_in = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         sweep_ff    <= '0;
         phase_ff    <= PH_LEN_HI;
         seg_rem_ff  <= '0;
         nc_ff       <= '0;
         cur_len_ff  <= '0;
         left_ff     <= '0;
         sym_left_ff <= '0;
         act_ff      <= '0;
         sticky_ff   <= '0;
         drop_ff     <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            lc_ff[i] <= 8'h00;
         end
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         phase_ff    <= phase_in;
         seg_rem_ff  <= seg_rem_in;
         nc_ff       <= nc_in;
         cur_len_ff  <= cur_len_in;
         left_ff     <= left_in;
         sym_left_ff <= sym_left_in;
         act_ff      <= act_in;
         sticky_ff   <= sticky_in;
         drop_ff     <= drop_in;
         lc_ff       <= lc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff        <= in_in;
      err_ff       <= err_in;
      emit_ff      <= emit_in;
      code_ff      <= code_in;
      len_ff       <= len_in;
      valid_ff     <= valid_in;
      sym_ff       <= sym_in;
      fill_ff      <= fill_in;
      fill_cnt_ff  <= fill_cnt_in;
      fill_last_ff <= fill_last_in;
      res_ff       <= res_in;
   end
endmodule
`default_nettype wire

FILE: hdl/jpeg_dht_huffman_table_builder_top.sv
// Top level of the JPEG DHT Huffman table builder: stream ports and result register.
// The block takes a DHT segment one byte per transfer (tuser 0) and builds canonical
// Huffman decode tables: fast tables indexed by the leading FAST_BITS code bits, per-length
// overflow lists for longer codes, and the code length of every symbol; tuser 1 and 2 read a
// fast entry or an overflow slot back. Items are handled one at a time. A fast or overflow
// read makes up to two memory reads. A class/id byte starts a pass that empties the table's
// fast memory (2^FAST_BITS entries) one entry per cycle. A symbol byte steps over the code
// lengths in the canonical search one per cycle (up to 16), then fills its fast entries one
// per cycle, up to 2^(FAST_BITS-1) (256 by default), on the single write port of the fast
// memory. After reset a clearing pass over the larger of the fast memory depth and the
// symbol length memory depth runs before the first item is taken. One result register
// sits on the output, so the next item is taken while a result waits for rsp_tready.
`default_nettype none
module jpeg_dht_huffman_table_builder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // data_byte[7:0], sel_class[8], sel_table[10:9], sel_index[19:11], sel_length[22:20]
   input  wire logic [23:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // symbol[8:0], code[24:9], code_length[29:25], entry_valid[30], error_code[33:31]
   output logic      [39:0] rsp_tdata,
   // kind[1:0]
   output logic      [1:0]  rsp_tuser,
   // segment_done
   output logic             rsp_tlast
);
   jdht_pkg::req_type req;
   jdht_pkg::res_type res;
   jdht_pkg::res_type rsp_data_ff;
   logic              res_valid;
   logic              res_ready;
   logic              rsp_valid_ff, rsp_valid_in;

   // Unpack the request transfer.
   assign req.func       = req_tuser;
   assign req.data_byte  = req_tdata[7:0];
   assign req.sel_class  = req_tdata[8];
   assign req.sel_table  = req_tdata[10:9];
   assign req.sel_index  = req_tdata[19:11];
   assign req.sel_length = req_tdata[22:20];

   jdht_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req(req), .req_ready(req_tready),
      .res_valid(res_valid), .res(res), .res_ready(res_ready));

   // Load the output register whenever it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.kind;
   assign rsp_tlast  = rsp_data_ff.segment_done;
   assign rsp_tdata  = {6'b000000, rsp_data_ff.error_code, rsp_data_ff.entry_valid,
                        rsp_data_ff.code_length, rsp_data_ff.code, rsp_data_ff.symbol};
endmodule
`default_nettype wire

FILE: hdl/jdht_checker.sv
// Port-level checker for the DHT table builder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module jdht_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   // Reset starts the clearing pass: nothing is taken and nothing is shown.
   `JDHT_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !req_tready && !rsp_tvalid)
   // A stalled result holds.
   `JDHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   // Only a segment byte can end a segment.
   `JDHT_ASSERT_IMPLY(a_done_kind, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == jdht_pkg::KIND_DHT)
   // An empty fast entry reads as symbol -1; a filled one is a byte value.
   `JDHT_ASSERT_IMPLY(a_fast_sym, clock, reset, rsp_tvalid && rsp_tuser == jdht_pkg::KIND_FAST, rsp_tdata[30] ? !rsp_tdata[8] : (rsp_tdata[8:0] == jdht_pkg::SYM_EMPTY))
   // Reads report no error.
   `JDHT_ASSERT_IMPLY(a_read_noerr, clock, reset, rsp_tvalid && rsp_tuser != jdht_pkg::KIND_DHT, rsp_tdata[33:31] == jdht_pkg::ERR_NONE && !rsp_tlast)
endmodule

bind jpeg_dht_huffman_table_builder_top jdht_checker u_jdht_checker (.*);
`default_nettype wire
